@@ hw/rtl/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants for the receive frame deframer
// Byte classes passed from the front to the back, frame limits, status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int unsigned LEN_W       = 9;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned M_TDATA_W   = 40;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]  MIN_FRAME     = 9'd30;
    localparam logic [LEN_W-1:0]  MAX_FRAME     = 9'd256;
    localparam logic [LEN_W-1:0]  RESET_FRAME   = 9'd142;
    localparam logic [LEN_W-1:0]  PAYLOAD_START = 9'd3;
    localparam logic [LEN_W-1:0]  MODE_POS      = 9'd2;
    localparam logic [BYTE_W-1:0] HEAD_MARK     = 8'd0;
    localparam logic [BYTE_W-1:0] TAIL_MARK     = 8'd255;
    localparam logic [IDX_W-1:0]  WORDS_SHORT   = 3'd4;
    localparam logic [IDX_W-1:0]  WORDS_LONG    = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_TAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_HEAD = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_SUM  = 2'd3;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        OP_SKIP,
        OP_HEAD,
        OP_MODE,
        OP_PAYLOAD,
        OP_CKHI,
        OP_CKLO,
        OP_TAIL
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [1:0]        lane;   // byte lane within a payload word
        logic [BYTE_W-1:0] data;
    } t_op;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len < MIN_FRAME) res = MIN_FRAME;
        if (len > MAX_FRAME) res = MAX_FRAME;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rfd_front.sv @@
// ----------------------------------------------------------------------------
// rfd_front: byte intake and classification
// Holds the frame length and byte position, tags each byte with its role.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rfd_pkg::LEN_W-1:0]      i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [rfd_pkg::BYTE_W-1:0]     i_s_tdata,
    input  wire rfd_pkg::t_q_status             i_q_status,
    output logic                                o_push,
    output rfd_pkg::t_op                        o_op
);

    logic [rfd_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [rfd_pkg::LEN_W-1:0] r_len_m1, r_len_m2, r_len_m3;
    logic [rfd_pkg::LEN_W-1:0] w_len;
    rfd_pkg::t_op_kind         w_kind;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_q_status.full;
    assign o_push      = i_s_tvalid && o_s_tready;
    assign w_len       = rfd_pkg::clamp_len(i_cfg_data);

    always_comb begin
        if (r_pos >= r_len_m1) begin
            w_kind = rfd_pkg::OP_TAIL;
        end else if (r_pos == '0) begin
            w_kind = rfd_pkg::OP_HEAD;
        end else if (r_pos == rfd_pkg::MODE_POS) begin
            w_kind = rfd_pkg::OP_MODE;
        end else if (r_pos >= rfd_pkg::PAYLOAD_START && r_pos < r_len_m3) begin
            w_kind = rfd_pkg::OP_PAYLOAD;
        end else if (r_pos == r_len_m3) begin
            w_kind = rfd_pkg::OP_CKHI;
        end else if (r_pos == r_len_m2) begin
            w_kind = rfd_pkg::OP_CKLO;
        end else begin
            w_kind = rfd_pkg::OP_SKIP;
        end
        n_pos = (w_kind == rfd_pkg::OP_TAIL) ? '0 : r_pos + 1'b1;
    end

    assign o_op.kind = w_kind;
    assign o_op.lane = r_pos[1:0] - rfd_pkg::PAYLOAD_START[1:0];
    assign o_op.data = i_s_tdata;

    // lengths kept pre-offset so the classify compares are plain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len_m1 <= rfd_pkg::RESET_FRAME - 9'd1;
            r_len_m2 <= rfd_pkg::RESET_FRAME - 9'd2;
            r_len_m3 <= rfd_pkg::RESET_FRAME - 9'd3;
        end else begin
            if (o_push) begin
                r_pos <= n_pos;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_len_m1 <= w_len - 9'd1;
                r_len_m2 <= w_len - 9'd2;
                r_len_m3 <= w_len - 9'd3;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rfd_queue.sv @@
// ----------------------------------------------------------------------------
// rfd_queue: short FIFO of classified bytes
// Decouples the intake from the checker so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_queue #(
    parameter int unsigned DEPTH = rfd_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rfd_pkg::t_op  i_op,
    input  wire logic          i_pop,
    output rfd_pkg::t_op       o_op,
    output rfd_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rfd_pkg::t_op       r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push, w_do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_op           = r_mem[r_rd_ptr];
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && !w_do_pop |=> o_status.full)
        else $error("queue drained without a pop");

endmodule

`default_nettype wire

@@ hw/rtl/rfd_back.sv @@
// ----------------------------------------------------------------------------
// rfd_back: frame checker and result stage
// Runs the checksum, assembles payload words and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rfd_pkg::t_q_status                i_q_status,
    input  wire rfd_pkg::t_op                      i_op,
    output logic                                   o_pop,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [rfd_pkg::M_TDATA_W-1:0]          o_m_tdata,
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast
);

    logic [rfd_pkg::SUM_W-1:0]    r_sum;
    logic                         r_head_ok;
    logic                         r_six;
    logic [23:0]                  r_asm;
    logic [rfd_pkg::IDX_W-1:0]    r_words;
    logic [rfd_pkg::BYTE_W-1:0]   r_ck_hi;

    logic                         r_valid;
    logic                         r_kind;
    logic [rfd_pkg::WORD_W-1:0]   r_word;
    logic [rfd_pkg::IDX_W-1:0]    r_idx;
    logic [rfd_pkg::STATUS_W-1:0] r_status;
    logic                         r_last;

    logic [rfd_pkg::IDX_W-1:0]    w_limit;
    logic [rfd_pkg::STATUS_W-1:0] w_status;
    logic                         w_room;
    logic                         w_emit;

    assign w_room  = !r_valid || i_m_tready;
    assign o_pop   = i_q_status.valid && w_room;
    assign w_limit = r_six ? rfd_pkg::WORDS_LONG : rfd_pkg::WORDS_SHORT;

    // popped item loads a result: the tail, or the last lane of a kept word
    assign w_emit  = o_pop && ((i_op.kind == rfd_pkg::OP_TAIL) ||
                               (i_op.kind == rfd_pkg::OP_PAYLOAD && r_words < w_limit &&
                                i_op.lane == 2'd3));

    always_comb begin
        if (i_op.data != rfd_pkg::TAIL_MARK) begin
            w_status = rfd_pkg::STAT_BAD_TAIL;
        end else if (!r_head_ok) begin
            w_status = rfd_pkg::STAT_BAD_HEAD;
        end else if (r_sum != '0) begin
            w_status = rfd_pkg::STAT_BAD_SUM;
        end else begin
            w_status = rfd_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_head_ok <= 1'b0;
            r_six     <= 1'b0;
            r_asm     <= '0;
            r_words   <= '0;
            r_ck_hi   <= '0;
            r_valid   <= 1'b0;
            r_kind    <= rfd_pkg::KIND_WORD;
            r_word    <= '0;
            r_idx     <= '0;
            r_status  <= rfd_pkg::STAT_OK;
            r_last    <= 1'b0;
        end else begin
            r_valid <= w_emit || (r_valid && !i_m_tready);
            if (o_pop) begin
                unique case (i_op.kind)
                    rfd_pkg::OP_TAIL: begin
                        r_kind   <= rfd_pkg::KIND_STATUS;
                        r_word   <= '0;
                        r_idx    <= '0;
                        r_status <= w_status;
                        r_last   <= 1'b1;
                    end
                    rfd_pkg::OP_HEAD: begin
                        r_head_ok <= (i_op.data == rfd_pkg::HEAD_MARK);
                        r_sum     <= '0;
                        r_words   <= '0;
                        r_asm     <= '0;
                        r_ck_hi   <= '0;
                        r_six     <= 1'b0;
                    end
                    rfd_pkg::OP_MODE: begin
                        r_six <= i_op.data[0];
                    end
                    rfd_pkg::OP_PAYLOAD: begin
                        r_sum <= r_sum + {8'd0, i_op.data};
                        if (r_words < w_limit) begin
                            case (i_op.lane)
                                2'd0:    r_asm[7:0]   <= i_op.data;
                                2'd1:    r_asm[15:8]  <= i_op.data;
                                2'd2:    r_asm[23:16] <= i_op.data;
                                default: begin
                                    r_kind   <= rfd_pkg::KIND_WORD;
                                    r_word   <= {i_op.data, r_asm};
                                    r_idx    <= r_words;
                                    r_status <= rfd_pkg::STAT_OK;
                                    r_last   <= 1'b0;
                                    r_words  <= r_words + 1'b1;
                                    r_asm    <= '0;
                                end
                            endcase
                        end
                    end
                    rfd_pkg::OP_CKHI: begin
                        r_ck_hi <= i_op.data;
                    end
                    rfd_pkg::OP_CKLO: begin
                        // zero after this means the received checksum matched
                        r_sum <= r_sum ^ {r_ck_hi, i_op.data};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {3'd0, r_status, r_idx, r_word};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    a_words_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words <= rfd_pkg::WORDS_LONG)
        else $error("too many payload words in one frame");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == rfd_pkg::KIND_STATUS |-> r_word == '0 && r_idx == '0 && r_last)
        else $error("status item carries payload fields");

    a_head_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_op.kind == rfd_pkg::OP_HEAD |=> r_words == '0 && r_sum == '0)
        else $error("frame state not cleared at head");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_m_tready |=> r_valid)
        else $error("pending result lost while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/rx_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// rx_frame_deframer_unit: fixed-length receive frame checker
// One received byte in per item; payload words and a frame status out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) takes one frame byte per item. Master stream (o_m_*)
//   emits payload words (tuser 0) and one status item per frame (tuser 1,
//   tlast 1). The user must write the frame length register on the cfg
//   channel only while no bytes are in flight; the block does not enforce
//   it. Lengths below 30 or above 256 are clamped. Throughput: one byte per
//   cycle sustained while i_m_tready is high. The intake classifies each
//   byte into a 2-entry queue; the checker pops one entry a cycle while the
//   output register has room and loads it; that register drives o_m_tvalid.
//   A stall on i_m_tready holds the output register; the queue absorbs up to
//   two more bytes, then o_s_tready drops until the output drains.
//   Reset clears the position, checksum and queue; the frame length returns
//   to 142.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_frame_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = rfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rfd_pkg::LEN_W-1:0]     i_cfg_data,   // frame_length
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [rfd_pkg::BYTE_W-1:0]    i_s_tdata,    // rx_byte
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [31:0] payload_word, [34:32] word_index, [36:35] frame_status, rest 0
    output logic [rfd_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser,    // result_kind
    output logic                               o_m_tlast     // frame_last
);

    rfd_pkg::t_q_status w_q_status;
    rfd_pkg::t_op       w_in_op, w_out_op;
    logic               w_push, w_pop;

    rfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_op        (w_in_op)
    );

    rfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_in_op),
        .i_pop    (w_pop),
        .o_op     (w_out_op),
        .o_status (w_q_status)
    );

    rfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_op       (w_out_op),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
